>>> rtl/mbpr_pkg.sv
// ----------------------------------------------------------------------------
// mbpr_pkg: shared types and constants for the masked byte pattern replacer
// Register map, configuration record and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package mbpr_pkg;

	localparam int BYTE_W    = 8;
	localparam int CFG_W     = 64;
	localparam int APB_ADDR_W = 6;
	localparam int REG_IDX_LSB = 3;
	localparam int REG_IDX_W  = APB_ADDR_W - REG_IDX_LSB;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

	localparam logic [3:0] PLEN_RESET = 4'd1;
	localparam logic       REN_RESET  = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_BYTES     = 3'd0,
		REG_PATTERN_MASK      = 3'd1,
		REG_REPLACEMENT_BYTES = 3'd2,
		REG_REPLACEMENT_MASK  = 3'd3,
		REG_PATTERN_LENGTH    = 3'd4,
		REG_REPLACE_ENABLE    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] pattern_bytes;
		logic [CFG_W-1:0] pattern_mask;
		logic [CFG_W-1:0] replacement_bytes;
		logic [CFG_W-1:0] replacement_mask;
		logic [3:0]       pattern_length;
		logic             replace_enable;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              mstart;
		logic              found;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/mbpr_cfg.sv
// ----------------------------------------------------------------------------
// mbpr_cfg: configuration register file
// APB-style write/read of the six pattern and replacement registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpr_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mbpr_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [mbpr_pkg::CFG_W-1:0]        pwdata,
	output logic      [mbpr_pkg::CFG_W-1:0]        prdata,
	output mbpr_pkg::cfg_t                         cfg
);

	mbpr_pkg::cfg_t   cfg_q;
	mbpr_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx   = mbpr_pkg::reg_idx_t'(paddr[mbpr_pkg::APB_ADDR_W-1:mbpr_pkg::REG_IDX_LSB]);
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes     <= '0;
			cfg_q.pattern_mask      <= '0;
			cfg_q.replacement_bytes <= '0;
			cfg_q.replacement_mask  <= '0;
			cfg_q.pattern_length    <= mbpr_pkg::PLEN_RESET;
			cfg_q.replace_enable    <= mbpr_pkg::REN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				mbpr_pkg::REG_PATTERN_BYTES:     cfg_q.pattern_bytes     <= pwdata;
				mbpr_pkg::REG_PATTERN_MASK:      cfg_q.pattern_mask      <= pwdata;
				mbpr_pkg::REG_REPLACEMENT_BYTES: cfg_q.replacement_bytes <= pwdata;
				mbpr_pkg::REG_REPLACEMENT_MASK:  cfg_q.replacement_mask  <= pwdata;
				mbpr_pkg::REG_PATTERN_LENGTH:    cfg_q.pattern_length    <= pwdata[3:0];
				mbpr_pkg::REG_REPLACE_ENABLE:    cfg_q.replace_enable    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			mbpr_pkg::REG_PATTERN_BYTES:     prdata = cfg_q.pattern_bytes;
			mbpr_pkg::REG_PATTERN_MASK:      prdata = cfg_q.pattern_mask;
			mbpr_pkg::REG_REPLACEMENT_BYTES: prdata = cfg_q.replacement_bytes;
			mbpr_pkg::REG_REPLACEMENT_MASK:  prdata = cfg_q.replacement_mask;
			mbpr_pkg::REG_PATTERN_LENGTH:    prdata = {60'd0, cfg_q.pattern_length};
			mbpr_pkg::REG_REPLACE_ENABLE:    prdata = {63'd0, cfg_q.replace_enable};
			default:                         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/mbpr_core.sv
// ----------------------------------------------------------------------------
// mbpr_core: match window engine
// Insert, evaluate the oldest, rewrite, shift one word per cycle if res_free.
// ----------------------------------------------------------------------------
`default_nettype none

module mbpr_core #(
	parameter int MAX_PATTERN_BYTES = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire mbpr_pkg::cfg_t                  cfg,
	input  wire logic                            item_valid,
	input  wire logic [mbpr_pkg::BYTE_W-1:0]     item_data,
	input  wire logic                            item_last,
	output logic                                 item_take,
	input  wire logic                            res_free,
	output logic                                 res_valid,
	output mbpr_pkg::result_t                    res
);

	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int CNT_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int BW    = mbpr_pkg::BYTE_W;

	logic [BW-1:0]    win_q  [MAX_PATTERN_BYTES];
	logic [BW-1:0]    win_c  [MAX_PATTERN_BYTES];
	logic [BW-1:0]    win_r  [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] mark_q, mark_c;
	logic [CNT_W-1:0] fill_q, fill_c, fill_after;
	logic [IDX_W-1:0] skip_q, skip_n;
	logic             found_q, found_c;
	logic             busy_q, flush_q, busy_n;

	logic [CNT_W-1:0] len_c;
	logic             take, last_c, active, need, emit, eval, hit, all_ok, final_word;
	logic [MAX_PATTERN_BYTES-1:0] lane_ok;

	// clamp the programmed length into 1..MAX
	always_comb begin
		if (cfg.pattern_length == 4'd0) begin
			len_c = CNT_W'(1);
		end else if (cfg.pattern_length > 4'(MAX_PATTERN_BYTES)) begin
			len_c = CNT_W'(MAX_PATTERN_BYTES);
		end else begin
			len_c = cfg.pattern_length[CNT_W-1:0];
		end
	end

	always_comb begin
		win_c  = win_q;
		mark_c = mark_q;
		fill_c = fill_q;
		take   = item_valid & ~busy_q;
		if (take) begin
			win_c[fill_q[IDX_W-1:0]]  = item_data;
			mark_c[fill_q[IDX_W-1:0]] = 1'b0;
			fill_c = fill_q + CNT_W'(1);
		end
		last_c = take ? item_last : flush_q;
		active = take | busy_q;
		eval   = (fill_c >= len_c);
		need   = active & (eval | (last_c & (fill_c != '0)));
		emit   = need & res_free;

		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			lane_ok[i] = (CNT_W'(i) >= len_c) ||
				((win_c[i] & cfg.pattern_mask[i*BW +: BW]) == cfg.pattern_bytes[i*BW +: BW]);
		end
		all_ok = &lane_ok;
		hit    = eval & all_ok & (skip_q == '0);

		win_r = win_c;
		if (hit && cfg.replace_enable) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				if (CNT_W'(i) < len_c) begin
					win_r[i] = (cfg.replacement_bytes[i*BW +: BW] & cfg.replacement_mask[i*BW +: BW]) |
						(win_c[i] & (cfg.replacement_mask[i*BW +: BW] ^ mbpr_pkg::BYTE_ONES));
				end
			end
		end
		found_c = found_q | hit;

		if (!eval) begin
			skip_n = skip_q;
		end else if (skip_q != '0) begin
			skip_n = skip_q - IDX_W'(1);
		end else if (hit) begin
			skip_n = IDX_W'(len_c - CNT_W'(1));
		end else begin
			skip_n = skip_q;
		end

		final_word = last_c & (fill_c == CNT_W'(1));
		fill_after = emit ? (fill_c - CNT_W'(1)) : fill_c;
		busy_n     = active & ((fill_after >= len_c) | (last_c & (fill_after != '0)));
	end

	assign item_take  = take;
	assign res_valid  = emit;
	assign res.data   = win_r[0];
	assign res.mstart = mark_c[0] | hit;
	assign res.found  = found_c;
	assign res.last   = final_word;

	// window payload: shift on every emitted word, top fills with zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				win_q[i] <= '0;
			end
		end else if (emit) begin
			for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
				win_q[i] <= win_r[i+1];
			end
			win_q[MAX_PATTERN_BYTES-1] <= '0;
		end else begin
			win_q <= win_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= '0;
			fill_q  <= '0;
			skip_q  <= '0;
			found_q <= 1'b0;
			busy_q  <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			busy_q  <= busy_n;
			flush_q <= busy_n & last_c;
			if (emit) begin
				fill_q <= fill_after;
				if (final_word) begin
					mark_q  <= '0;
					skip_q  <= '0;
					found_q <= 1'b0;
				end else begin
					mark_q  <= {1'b0, mark_c[MAX_PATTERN_BYTES-1:1]};
					skip_q  <= skip_n;
					found_q <= found_c;
				end
			end else begin
				fill_q <= fill_c;
				mark_q <= mark_c;
			end
		end
	end

	a_flush_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> busy_q)
		else $error("flush pending without a busy item");

	a_stall_holds_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !emit) |=> $stable(fill_q))
		else $error("window fill moved while stalled");

	a_stream_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res.last) |=> (found_q == 1'b0 && skip_q == '0 && fill_q == '0))
		else $error("stream state not cleared after final word");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (fill_q < CNT_W'(MAX_PATTERN_BYTES)))
		else $error("window over full while idle");

endmodule

`default_nettype wire

>>> rtl/masked_byte_pattern_replace.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_replace: masked byte search and replace on a stream
// Top level: input register, window engine, result register, APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one stream byte per word with
//   is_last on the final byte. Output channel (out_valid / out_stall) returns
//   each byte once it leaves the pattern window, with match_start on the first
//   byte of every match, found_any as a sticky per-stream flag and out_last on
//   the final byte. Program the registers through the APB port while idle.
//   Path: a byte that leaves the window reaches the output after the word
//   that pushed it out passes the input register and the engine loads the
//   result register with it; the window itself delays the stream by the
//   clamped pattern_length minus one words.
//   Throughput: one word per cycle in steady state while out_stall is low.
//   A word that carries is_last, or a word after pattern_length was lowered,
//   produces up to MAX_PATTERN_BYTES output words, one per unstalled cycle
//   through the single result register; the input stalls while they drain.
//   Reset: arst_n clears the window, counters, flags and both valid bits, and
//   loads register defaults (length 1, replace enabled).
//   Output stall: the result register holds; the engine then holds its word
//   and the input register, and in_stall rises once that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_replace #(
	parameter int MAX_PATTERN_BYTES = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// APB configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [mbpr_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [mbpr_pkg::CFG_W-1:0]         pwdata,
	output logic      [mbpr_pkg::CFG_W-1:0]         prdata,
	output logic                                    pready,
	// input stream
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [mbpr_pkg::BYTE_W-1:0]        data_byte,
	input  wire logic                               is_last,
	// output stream
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic      [mbpr_pkg::BYTE_W-1:0]        out_byte,
	output logic                                    out_last,
	output logic                                    match_start,
	output logic                                    found_any
);

	mbpr_pkg::cfg_t    cfg;
	mbpr_pkg::result_t res;
	mbpr_pkg::result_t res_q;

	logic                          valid_s1;
	logic [mbpr_pkg::BYTE_W-1:0]   data_s1;
	logic                          last_s1;
	logic                          item_take;
	logic                          res_valid;
	logic                          res_free;
	logic                          out_valid_q;

	assign pready = 1'b1;

	mbpr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// hold the input word while the engine is still draining the previous one
	assign in_stall = valid_s1 & ~item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	mbpr_core #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (valid_s1),
		.item_data  (data_s1),
		.item_last  (last_s1),
		.item_take  (item_take),
		.res_free   (res_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register: advance when empty or when the receiver takes the word
	assign res_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = res_q.data;
	assign out_last    = res_q.last;
	assign match_start = res_q.mstart;
	assign found_any   = res_q.found;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: masked byte pattern search and replace
// Drives byte streams and APB register writes into the block, predicts every
// output word with a behavioral model of the pattern window, and compares the
// words in order. Covers defaults, out-of-range lengths, unmatchable patterns,
// length lowered mid-stream, stream flush and random streams with embedded
// pattern occurrences under random stalls on both channels and a long receiver hold.
// ----------------------------------------------------------------------------

module testbench;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 6;
	localparam int DRAIN_CYC   = 12;	// flush of eight words plus both pipeline registers
	localparam int TAIL_CYC    = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYC    = 60;
	localparam int MAX_PRINTED = 40;

	// ------------------------------------------------------------------------
	// Predictor and store of expected output words
	// ------------------------------------------------------------------------
	class stream_rewrite_board;
		mbpr_pkg::cfg_t    regs;
		logic [7:0]        win[8];
		logic              marks[8];
		int unsigned       fill;
		int unsigned       skip;
		logic              found;
		mbpr_pkg::result_t expected_words[$];
		mbpr_pkg::result_t step_words[$];
		int                errors;
		int                words_checked;
		int                hit_count;
		int                streams;

		function new();
			regs = '0;
			regs.pattern_length = mbpr_pkg::PLEN_RESET;
			regs.replace_enable = mbpr_pkg::REN_RESET;
			for (int i = 0; i < 8; i++) begin
				win[i] = '0;
				marks[i] = 1'b0;
			end
			fill = 0;
			skip = 0;
			found = 1'b0;
			errors = 0;
			words_checked = 0;
			hit_count = 0;
			streams = 0;
		endfunction

		function int unsigned active_len();
			int unsigned len;
			len = regs.pattern_length;
			if (len < 1) len = 1;
			if (len > 8) len = 8;
			return len;
		endfunction

		function logic [7:0] lane(logic [63:0] r, int unsigned i);
			return r[8*i +: 8];
		endfunction

		function void set_reg(mbpr_pkg::reg_idx_t idx, logic [63:0] v);
			case (idx)
				mbpr_pkg::REG_PATTERN_BYTES:     regs.pattern_bytes = v;
				mbpr_pkg::REG_PATTERN_MASK:      regs.pattern_mask = v;
				mbpr_pkg::REG_REPLACEMENT_BYTES: regs.replacement_bytes = v;
				mbpr_pkg::REG_REPLACEMENT_MASK:  regs.replacement_mask = v;
				mbpr_pkg::REG_PATTERN_LENGTH:    regs.pattern_length = v[3:0];
				mbpr_pkg::REG_REPLACE_ENABLE:    regs.replace_enable = v[0];
				default: ;
			endcase
		endfunction

		// check the oldest held byte as a match start, rewrite on a hit
		function void judge_oldest(int unsigned len);
			logic       hit;
			logic [7:0] m;
			hit = 1'b1;
			if (skip > 0) begin
				skip--;
				return;
			end
			for (int unsigned i = 0; i < len; i++)
				if ((win[i] & lane(regs.pattern_mask, i)) != lane(regs.pattern_bytes, i))
					hit = 1'b0;
			if (!hit)
				return;
			found = 1'b1;
			marks[0] = 1'b1;
			hit_count++;
			if (regs.replace_enable) begin
				for (int unsigned i = 0; i < len; i++) begin
					m = lane(regs.replacement_mask, i);
					win[i] = (lane(regs.replacement_bytes, i) & m) | (win[i] & ~m);
				end
			end
			skip = (len - 1) & 7;
		endfunction

		function void shift_out();
			mbpr_pkg::result_t w;
			w.data = win[0];
			w.last = 1'b0;
			w.mstart = marks[0];
			w.found = found;
			step_words = {step_words, w};
			for (int i = 0; i < 7; i++) begin
				win[i] = win[i+1];
				marks[i] = marks[i+1];
			end
			win[7] = '0;
			marks[7] = 1'b0;
			if (fill > 0) fill--;
		endfunction

		function void note_byte(logic [7:0] b, logic l);
			int unsigned len;
			len = active_len();
			step_words.delete();
			if (fill >= 8) fill = 7;
			win[fill] = b;
			marks[fill] = 1'b0;
			fill++;
			while (fill >= len) begin
				judge_oldest(len);
				shift_out();
			end
			if (l) begin
				while (fill > 0)
					shift_out();
				if (step_words.size() > 0)
					step_words[step_words.size() - 1].last = 1'b1;
				skip = 0;
				found = 1'b0;
				for (int i = 0; i < 8; i++) marks[i] = 1'b0;
				streams++;
			end
			foreach (step_words[i])
				expected_words = {expected_words, step_words[i]};
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_word(mbpr_pkg::result_t got);
			mbpr_pkg::result_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word %02h last=%0b", got.data, got.last));
				return;
			end
			want = expected_words.pop_front();
			if (got.data !== want.data)
				report($sformatf("word %0d out_byte %02h, want %02h",
					words_checked, got.data, want.data));
			if (got.last !== want.last)
				report($sformatf("word %0d out_last %0b, want %0b",
					words_checked, got.last, want.last));
			if (got.mstart !== want.mstart)
				report($sformatf("word %0d match_start %0b, want %0b",
					words_checked, got.mstart, want.mstart));
			if (got.found !== want.found)
				report($sformatf("word %0d found_any %0b, want %0b",
					words_checked, got.found, want.found));
			words_checked++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Signals
	// ------------------------------------------------------------------------
	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [mbpr_pkg::APB_ADDR_W-1:0] paddr;
	logic [mbpr_pkg::CFG_W-1:0]      pwdata;
	logic [mbpr_pkg::CFG_W-1:0]      prdata;
	logic                            pready;
	logic                            in_valid;
	logic                            in_stall;
	logic [mbpr_pkg::BYTE_W-1:0]     data_byte;
	logic                            is_last;
	logic                            out_valid;
	logic                            out_stall;
	logic [mbpr_pkg::BYTE_W-1:0]     out_byte;
	logic                            out_last;
	logic                            match_start;
	logic                            found_any;

	stream_rewrite_board board = new();

	logic in_fire = 1'b0;	// word taken at the most recent rising edge
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   hold_req = 0;
	int   cycle_count = 0;
	int   reg_writes = 0;
	int   bytes_sent = 0;

	masked_byte_pattern_replace dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.out_last    (out_last),
		.match_start (match_start),
		.found_any   (found_any)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Sample both channels at the rising edge. Outputs of the block settle
	// after the edge, so these reads see the values that were accepted.
	always @(posedge clk) begin
		mbpr_pkg::result_t got;
		if (out_valid === 1'b1 && out_stall == 1'b0) begin
			got.data = out_byte;
			got.last = out_last;
			got.mstart = match_start;
			got.found = found_any;
			board.check_word(got);
		end
		if (in_valid == 1'b1 && in_stall === 1'b0)
			board.note_byte(data_byte, is_last);
		in_fire <= (in_valid == 1'b1 && in_stall === 1'b0);
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, board.pending());
			$display("** masked_byte_pattern_replace: FAILED **");
			$finish;
		end
	end

	// Receiver: random stall at the current rate, or a long hold when asked.
	// The hold is counted here so the sender keeps pushing words meanwhile.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers (all called at a falling edge)
	// ------------------------------------------------------------------------

	// Offer one word and hold it until the block takes it.
	task automatic send_word(logic [7:0] b, logic l);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= l;
		do @(negedge clk); while (!in_fire);
		bytes_sent++;
	endtask

	// Wait for every predicted word, then let result-less words settle.
	task automatic wait_drained();
		while (board.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic apb_write(mbpr_pkg::reg_idx_t idx, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_reg(idx, v);
		reg_writes++;
	endtask

	// Program all six registers; only ever done with the block idle.
	task automatic apply_config(logic [63:0] pb, logic [63:0] pm, logic [63:0] rb,
			logic [63:0] rm, logic [3:0] len, logic ren);
		wait_drained();
		apb_write(mbpr_pkg::REG_PATTERN_BYTES, pb);
		apb_write(mbpr_pkg::REG_PATTERN_MASK, pm);
		apb_write(mbpr_pkg::REG_REPLACEMENT_BYTES, rb);
		apb_write(mbpr_pkg::REG_REPLACEMENT_MASK, rm);
		apb_write(mbpr_pkg::REG_PATTERN_LENGTH, {60'd0, len});
		apb_write(mbpr_pkg::REG_REPLACE_ENABLE, {63'd0, ren});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random setting. Most patterns sit inside their care mask so they can hit;
	// a few are redrawn unmasked, and a lane with stray bits never matches.
	task automatic random_config(logic [3:0] len, int flavor);
		logic [63:0] pm, pb, rb, rm;
		case (flavor % 3)
			0: pm = rand64();
			1: pm = 64'hFFFF_FFFF_FFFF_FFFF;
			default: pm = rand64() | rand64();
		endcase
		pb = rand64() & pm;
		if ($urandom_range(99) < 15)
			pb = rand64();
		case ($urandom_range(3))
			0: begin
				rb = 64'hFFFF_FFFF_FFFF_FFFF;
				rm = 64'hFFFF_FFFF_FFFF_FFFF;
			end
			1: begin
				rb = rand64();
				rm = '0;
			end
			default: begin
				rb = rand64();
				rm = rand64();
			end
		endcase
		apply_config(pb, pm, rb, rm, len, (flavor % 4) != 3);
	endtask

	// Stream with embedded pattern occurrences, some with one bit flipped,
	// mixed with random bytes. Lower valid at the end.
	task automatic run_stream(int n_items, bit close);
		int unsigned len;
		int          sent;
		int          flip;
		logic [7:0]  pm, pb, b;
		len = board.active_len();
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 60) begin
				flip = ($urandom_range(99) < 15) ? $urandom_range(len - 1) : -1;
				for (int i = 0; i < len && sent < n_items; i++) begin
					pm = board.lane(board.regs.pattern_mask, i);
					pb = board.lane(board.regs.pattern_bytes, i);
					b = (pb & pm) | (8'($urandom) & ~pm);
					if (i == flip)
						b = b ^ (8'h01 << $urandom_range(7));
					send_word(b, close && sent == n_items - 1);
					sent++;
				end
			end else begin
				send_word(8'($urandom), close && sent == n_items - 1);
				sent++;
			end
		end
		in_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [3:0] plan_len[9];
		plan_len = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd5, 4'd0, 4'd2, 4'd8, 4'd7};

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		data_byte = '0;
		is_last = 1'b0;
		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset defaults: length one, empty mask, so every byte is a match
		// and an all-zero replace mask leaves it unchanged.
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		in_valid <= 1'b0;

		// Two-byte pattern in a run of three: leftmost match wins, no overlap;
		// flush the trailing pair at stream end.
		apply_config(64'h11_11, 64'hFF_FF, 64'h5A_A5, 64'h0F_F0, 4'd2, 1'b1);
		send_word(8'h11, 1'b0);
		send_word(8'h11, 1'b0);
		send_word(8'h11, 1'b0);
		send_word(8'h22, 1'b0);
		send_word(8'h11, 1'b0);
		send_word(8'h11, 1'b1);
		in_valid <= 1'b0;

		// Pattern bit outside the care mask: can never match.
		apply_config(64'h01, 64'hFE, 64'hFF, 64'hFF, 4'd1, 1'b1);
		send_word(8'h01, 1'b0);
		send_word(8'hFF, 1'b1);
		in_valid <= 1'b0;

		// Length above the maximum clamps to eight; search only. Leave five
		// bytes in the window, then lower the length to zero (treated as one)
		// mid-stream so the held bytes drain with the next word, now rewritten.
		apply_config(64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			4'd15, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'h01, 1'b0);
		in_valid <= 1'b0;
		apply_config(64'h0, 64'h0, 64'hC3C3_C3C3_C3C3_C3C3, 64'hFFFF_FFFF_FFFF_FFFF,
			4'd0, 1'b1);
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b1);
		in_valid <= 1'b0;

		// Random streams in three idling phases, three settings each.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 35;
					rx_idle_pct = 62;
				end
				1: begin
					tx_idle_pct = 62;
					rx_idle_pct = 35;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				random_config(plan_len[phase*3 + k], phase*3 + k);
				if (phase == 2 && k == 0) begin
					// long receiver hold while the sender keeps pushing
					hold_req = HOLD_CYC;
					run_stream(24, 1'b1);
				end else begin
					run_stream($urandom_range(8, 15), $urandom_range(99) < 80);
				end
			end
		end

		wait_drained();
		repeat (TAIL_CYC) @(negedge clk);

		$display("run covered %0d input bytes in %0d closed streams, %0d register writes",
			bytes_sent, board.streams, reg_writes);
		$display("checked %0d output words carrying %0d predicted matches, %0d mismatches",
			board.words_checked, board.hit_count, board.errors);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("** masked_byte_pattern_replace: PASSED **");
		end else begin
			if (board.pending() != 0)
				$display("%0d expected words never arrived", board.pending());
			$display("** masked_byte_pattern_replace: FAILED **");
		end
		$finish;
	end

endmodule

>>> masked_byte_pattern_replace.f
rtl/mbpr_pkg.sv
rtl/mbpr_cfg.sv
rtl/mbpr_core.sv
rtl/masked_byte_pattern_replace.sv
sim/testbench.sv
